[sv/epoch_ms_to_calendar_defines.svh]
// assertion macros shared by the checker of epoch_ms_to_calendar
// no dependencies; include by bare file name
`ifndef EPOCH_MS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_MS_TO_CALENDAR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define EP2C_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define EP2C_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ep2c_pkg.sv]
// types, constants and the day divider step for the epoch to calendar pipeline
// no dependencies
`timescale 1ns / 1ps

package ep2c_pkg;

    // latest accepted count: 4001-01-01 00:00:00.000
    localparam logic [63:0] LIMIT_MS = 64'h0000_3A4A_A17B_4000;

    // pipeline shape
    localparam int DAY_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = 5;
    localparam int CONV_STAGES        = 6;
    localparam int NUM_STAGES         = DAY_STAGES + CONV_STAGES + 1;

    // ms per day is 84375 * 1024
    localparam logic [16:0] DAY_DIVISOR = 17'd84375;

    // time of day split
    localparam logic [17:0] MS_RECIP  = 18'd134217;  // 2^24 / 125
    localparam logic [6:0]  MS_DIV    = 7'd125;
    localparam logic [11:0] MIN_RECIP = 12'd2184;    // 2^15 / 15
    localparam logic [5:0]  HR_RECIP  = 6'd34;       // 2^9 / 15
    localparam logic [3:0]  SIXTY_DIV = 4'd15;

    // julian day number conversion
    localparam logic [21:0] JDN_OFFSET  = 22'd2472632; // epoch jdn plus 32044
    localparam logic [17:0] DAYS_400Y   = 18'd146097;
    localparam logic [6:0]  RECIP_400Y  = 7'd114;      // 2^24 / 146097
    localparam logic [10:0] DAYS_4Y     = 11'd1461;
    localparam logic [7:0]  RECIP_4Y    = 8'd179;      // 2^18 / 1461
    localparam logic [7:0]  DAYS_5M     = 8'd153;
    localparam logic [3:0]  RECIP_5M    = 4'd13;       // 2^11 / 153
    localparam logic [7:0]  RECIP_5     = 8'd205;      // 2^10 / 5
    localparam logic [13:0] YEAR_SHIFT  = 14'd4800;

    typedef struct packed {
        logic        in_range;
        logic [16:0] rem;
        logic [19:0] quo;   // day count once all stages are done
        logic [19:0] dvd;
        logic [9:0]  low;   // ms bits below the 1024 factor
    } ep2c_ddiv_t;

    typedef struct packed {
        logic [4:0] hr;
        logic [5:0] mn;
        logic [5:0] sec;
        logic [9:0] ms;
    } ep2c_tod_t;

    typedef struct packed {
        logic [6:0] b;
        logic [6:0] d;
        logic [3:0] m;
        logic [7:0] r3;
    } ep2c_date_t;

    // restoring division, a few quotient bits
    function automatic ep2c_ddiv_t ep2c_div_steps(input ep2c_ddiv_t s);
        ep2c_ddiv_t  o;
        logic [17:0] trial;
        o = s;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
            trial = {o.rem, o.dvd[19]};
            o.dvd = {o.dvd[18:0], 1'b0};
            if (trial >= {1'b0, DAY_DIVISOR}) begin
                o.quo = {o.quo[18:0], 1'b1};
                o.rem = 17'(trial - {1'b0, DAY_DIVISOR});
            end
            else begin
                o.quo = {o.quo[18:0], 1'b0};
                o.rem = trial[16:0];
            end
        end
        return o;
    endfunction

endpackage

[sv/ep2c_day_div.sv]
// range check and long division of the ms count by ms per day
// depends on ep2c_pkg
`timescale 1ns / 1ps

module ep2c_day_div
    import ep2c_pkg::*;
(
    input  logic                  clk,
    input  logic [DAY_STAGES-1:0] en,
    input  logic [63:0]           ms_since_epoch,
    output ep2c_ddiv_t            day_q
);

    ep2c_ddiv_t seed;
    ep2c_ddiv_t st_reg  [DAY_STAGES];
    ep2c_ddiv_t st_next [DAY_STAGES];

    // drop the 2^10 factor of the divisor, top 16 bits start as remainder
    always_comb
    begin
        seed.in_range = (ms_since_epoch <= LIMIT_MS);
        seed.rem      = {1'b0, ms_since_epoch[45:30]};
        seed.quo      = '0;
        seed.dvd      = ms_since_epoch[29:10];
        seed.low      = ms_since_epoch[9:0];
    end

    for (genvar k = 0; k < DAY_STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign st_next[k] = ep2c_div_steps(seed);
        end
        else
        begin : g_rest
            assign st_next[k] = ep2c_div_steps(st_reg[k-1]);
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign day_q = st_reg[DAY_STAGES-1];

endmodule

[sv/ep2c_tod.sv]
// splits ms of day into hour, minute, second and millisecond
// depends on ep2c_pkg; reciprocal multiply with one correction per divide
`timescale 1ns / 1ps

module ep2c_tod
    import ep2c_pkg::*;
(
    input  logic                   clk,
    input  logic [CONV_STAGES-1:0] en,
    input  logic [26:0]            msd,
    output ep2c_tod_t              tod
);

    logic [41:0] prod0;
    logic [23:0] x_reg;
    logic [16:0] q0_reg, q0_next;
    logic [2:0]  lo3_reg;

    logic [23:0] mul1, rem1;
    logic [16:0] sod_reg, sod_next;
    logic [9:0]  ms1_reg, ms1_next;

    logic [26:0] prod2;
    logic [14:0] y_reg;
    logic [10:0] q2_reg, q2_next;
    logic [1:0]  slo_reg;
    logic [9:0]  ms2_reg;

    logic [14:0] mul3, rem3;
    logic [10:0] mod_reg, mod_next;
    logic [5:0]  sec3_reg, sec3_next;
    logic [9:0]  ms3_reg;

    logic [14:0] prod4;
    logic [8:0]  z_reg;
    logic [4:0]  q4_reg, q4_next;
    logic [1:0]  mlo_reg;
    logic [5:0]  sec4_reg;
    logic [9:0]  ms4_reg;

    logic [8:0]  mul5, rem5;
    ep2c_tod_t   out_reg, out_next;

    // ms of day / 1000 as (msd / 8) / 125
    always_comb
    begin
        prod0   = 42'(msd[26:3]) * 42'(MS_RECIP);
        q0_next = prod0[40:24];
    end

    always_comb
    begin
        mul1 = 24'(q0_reg) * 24'(MS_DIV);
        rem1 = x_reg - mul1;
        if (rem1 >= 24'(MS_DIV))
        begin
            sod_next = q0_reg + 17'd1;
            ms1_next = {7'(rem1 - 24'(MS_DIV)), lo3_reg};
        end
        else
        begin
            sod_next = q0_reg;
            ms1_next = {rem1[6:0], lo3_reg};
        end
    end

    // second of day / 60 as (sod / 4) / 15
    always_comb
    begin
        prod2   = 27'(sod_reg[16:2]) * 27'(MIN_RECIP);
        q2_next = prod2[25:15];
    end

    always_comb
    begin
        mul3 = 15'(q2_reg) * 15'(SIXTY_DIV);
        rem3 = y_reg - mul3;
        if (rem3 >= 15'(SIXTY_DIV))
        begin
            mod_next  = q2_reg + 11'd1;
            sec3_next = {4'(rem3 - 15'(SIXTY_DIV)), slo_reg};
        end
        else
        begin
            mod_next  = q2_reg;
            sec3_next = {rem3[3:0], slo_reg};
        end
    end

    // minute of day / 60
    always_comb
    begin
        prod4   = 15'(mod_reg[10:2]) * 15'(HR_RECIP);
        q4_next = prod4[13:9];
    end

    always_comb
    begin
        mul5 = 9'(q4_reg) * 9'(SIXTY_DIV);
        rem5 = z_reg - mul5;
        out_next.sec = sec4_reg;
        out_next.ms  = ms4_reg;
        if (rem5 >= 9'(SIXTY_DIV))
        begin
            out_next.hr = q4_reg + 5'd1;
            out_next.mn = {4'(rem5 - 9'(SIXTY_DIV)), mlo_reg};
        end
        else
        begin
            out_next.hr = q4_reg;
            out_next.mn = {rem5[3:0], mlo_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg   <= msd[26:3];
            q0_reg  <= q0_next;
            lo3_reg <= msd[2:0];
        end
        if (en[1])
        begin
            sod_reg <= sod_next;
            ms1_reg <= ms1_next;
        end
        if (en[2])
        begin
            y_reg   <= sod_reg[16:2];
            q2_reg  <= q2_next;
            slo_reg <= sod_reg[1:0];
            ms2_reg <= ms1_reg;
        end
        if (en[3])
        begin
            mod_reg  <= mod_next;
            sec3_reg <= sec3_next;
            ms3_reg  <= ms2_reg;
        end
        if (en[4])
        begin
            z_reg    <= mod_reg[10:2];
            q4_reg   <= q4_next;
            mlo_reg  <= mod_reg[1:0];
            sec4_reg <= sec3_reg;
            ms4_reg  <= ms3_reg;
        end
        if (en[5])
        begin
            out_reg <= out_next;
        end
    end

    assign tod = out_reg;

endmodule

[sv/ep2c_date.sv]
// day count to julian day number and the 400y / 4y / 5m divisions
// depends on ep2c_pkg; each divide is a reciprocal multiply then a correction
`timescale 1ns / 1ps

module ep2c_date
    import ep2c_pkg::*;
(
    input  logic                   clk,
    input  logic [CONV_STAGES-1:0] en,
    input  logic [19:0]            days,
    output ep2c_date_t             date
);

    logic [21:0] a;
    logic [23:0] x1_next;
    logic [30:0] prod0;
    logic [23:0] x1_reg;
    logic [6:0]  q0_reg, q0_next;

    logic [23:0] mul1, rem1;
    logic [6:0]  b1_reg, b1_next;
    logic [15:0] c_reg, c_next;

    logic [17:0] x2_next;
    logic [25:0] prod2;
    logic [17:0] x2_reg;
    logic [6:0]  q2_reg, q2_next;
    logic [6:0]  b2_reg;

    logic [17:0] mul3, rem3;
    logic [6:0]  d3_reg, d3_next;
    logic [8:0]  e_reg, e_next;
    logic [6:0]  b3_reg;

    logic [10:0] x3_next;
    logic [14:0] prod4;
    logic [10:0] x3_reg;
    logic [3:0]  q4_reg, q4_next;
    logic [6:0]  b4_reg, d4_reg;

    logic [10:0] mul5, rem5;
    ep2c_date_t  out_reg, out_next;

    // a = jdn + 32044, divide 4a + 3 by days per 400 years
    always_comb
    begin
        a       = 22'(days) + JDN_OFFSET;
        x1_next = {a, 2'b11};
        prod0   = 31'(x1_next) * 31'(RECIP_400Y);
        q0_next = prod0[30:24];
    end

    // c is the remainder over 4
    always_comb
    begin
        mul1 = 24'(q0_reg) * 24'(DAYS_400Y);
        rem1 = x1_reg - mul1;
        if (rem1 >= 24'(DAYS_400Y))
        begin
            b1_next = q0_reg + 7'd1;
            c_next  = 16'((rem1 - 24'(DAYS_400Y)) >> 2);
        end
        else
        begin
            b1_next = q0_reg;
            c_next  = rem1[17:2];
        end
    end

    always_comb
    begin
        x2_next = {c_reg, 2'b11};
        prod2   = 26'(x2_next) * 26'(RECIP_4Y);
        q2_next = prod2[24:18];
    end

    always_comb
    begin
        mul3 = 18'(q2_reg) * 18'(DAYS_4Y);
        rem3 = x2_reg - mul3;
        if (rem3 >= 18'(DAYS_4Y))
        begin
            d3_next = q2_reg + 7'd1;
            e_next  = 9'((rem3 - 18'(DAYS_4Y)) >> 2);
        end
        else
        begin
            d3_next = q2_reg;
            e_next  = rem3[10:2];
        end
    end

    // month index from march, over five-month blocks of 153 days
    always_comb
    begin
        x3_next = 11'(e_reg) * 11'd5 + 11'd2;
        prod4   = 15'(x3_next) * 15'(RECIP_5M);
        q4_next = prod4[14:11];
    end

    always_comb
    begin
        mul5       = 11'(q4_reg) * 11'(DAYS_5M);
        rem5       = x3_reg - mul5;
        out_next.b = b4_reg;
        out_next.d = d4_reg;
        if (rem5 >= 11'(DAYS_5M))
        begin
            out_next.m  = q4_reg + 4'd1;
            out_next.r3 = 8'(rem5 - 11'(DAYS_5M));
        end
        else
        begin
            out_next.m  = q4_reg;
            out_next.r3 = rem5[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg <= x1_next;
            q0_reg <= q0_next;
        end
        if (en[1])
        begin
            b1_reg <= b1_next;
            c_reg  <= c_next;
        end
        if (en[2])
        begin
            x2_reg <= x2_next;
            q2_reg <= q2_next;
            b2_reg <= b1_reg;
        end
        if (en[3])
        begin
            d3_reg <= d3_next;
            e_reg  <= e_next;
            b3_reg <= b2_reg;
        end
        if (en[4])
        begin
            x3_reg <= x3_next;
            q4_reg <= q4_next;
            b4_reg <= b3_reg;
            d4_reg <= d3_reg;
        end
        if (en[5])
        begin
            out_reg <= out_next;
        end
    end

    assign date = out_reg;

endmodule

[sv/epoch_ms_to_calendar.sv]
// pipeline depth: 11 register stages from input to output
// throughput: one transaction per cycle; each stage stalls only while it holds
//   a valid item that the next stage cannot take, so bubbles fill up
// reset: asynchronous, active low; clears the stage valid bits, data is not reset
// depends on ep2c_pkg, ep2c_day_div, ep2c_tod and ep2c_date
`timescale 1ns / 1ps

module epoch_ms_to_calendar
    import ep2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ms_valid,
    output logic        ms_ready,
    input  logic [63:0] ms_since_epoch,
    output logic        cal_valid,
    input  logic        cal_ready,
    output logic        in_range,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [9:0]  millisecond
);

    // stage map
    //   0..3  range check and long division by ms per day, 5 quotient bits each
    //   4..9  time of day split and julian day to date, side by side
    //   10    month / day fix-up, year sum, zeroing, output register

    logic [NUM_STAGES-1:0]  vld_reg, vld_next;
    logic [NUM_STAGES-1:0]  en;
    logic [CONV_STAGES-1:0] ir_reg;

    ep2c_ddiv_t day_q;
    ep2c_tod_t  tod_q;
    ep2c_date_t date_q;

    // final stage
    logic        wrap;
    logic [15:0] dom_prod;
    logic [13:0] yr_full;
    logic        in_range_reg, in_range_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  dom_reg, dom_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [9:0]  ms_reg, ms_next;

    // a stage may load when it is empty or its content moves on this cycle
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || cal_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? ms_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ms_ready  = en[0];
    assign cal_valid = vld_reg[NUM_STAGES-1];

    // day count and ms of day
    ep2c_day_div u_day_div (
        .clk            (clk),
        .en             (en[DAY_STAGES-1:0]),
        .ms_since_epoch (ms_since_epoch),
        .day_q          (day_q)
    );

    // hour / minute / second / millisecond from the division remainder
    ep2c_tod u_tod (
        .clk (clk),
        .en  (en[DAY_STAGES+CONV_STAGES-1:DAY_STAGES]),
        .msd ({day_q.rem, day_q.low}),
        .tod (tod_q)
    );

    // calendar date from the day count
    ep2c_date u_date (
        .clk  (clk),
        .en   (en[DAY_STAGES+CONV_STAGES-1:DAY_STAGES]),
        .days (day_q.quo),
        .date (date_q)
    );

    // range flag rides alongside the conversion stages
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CONV_STAGES; k++)
        begin
            if (en[DAY_STAGES+k])
            begin
                ir_reg[k] <= (k == 0) ? day_q.in_range : ir_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // month index counts from march, so january and february wrap to next year
    always_comb
    begin
        wrap     = (date_q.m >= 4'd10);
        dom_prod = 16'(date_q.r3) * 16'(RECIP_5);
        yr_full  = 14'(date_q.b) * 14'd100 + 14'(date_q.d) + 14'(wrap) - YEAR_SHIFT;

        in_range_next = ir_reg[CONV_STAGES-1];
        if (ir_reg[CONV_STAGES-1])
        begin
            year_next   = yr_full[11:0];
            month_next  = wrap ? (date_q.m - 4'd9) : (date_q.m + 4'd3);
            dom_next    = dom_prod[14:10] + 5'd1;
            hour_next   = tod_q.hr;
            minute_next = tod_q.mn;
            second_next = tod_q.sec;
            ms_next     = tod_q.ms;
        end
        else
        begin
            // beyond 4001-01-01: every field reads zero
            year_next   = '0;
            month_next  = '0;
            dom_next    = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            ms_next     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES-1])
        begin
            in_range_reg <= in_range_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            dom_reg      <= dom_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            ms_reg       <= ms_next;
        end
    end

    assign in_range     = in_range_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign millisecond  = ms_reg;

endmodule

[sv/epoch_ms_to_calendar_chk.sv]
// port-level checks for epoch_ms_to_calendar, bound to the top level
// depends on epoch_ms_to_calendar_defines.svh
`timescale 1ns / 1ps

`include "epoch_ms_to_calendar_defines.svh"

module epoch_ms_to_calendar_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        ms_valid,
    input logic        ms_ready,
    input logic [63:0] ms_since_epoch,
    input logic        cal_valid,
    input logic        cal_ready,
    input logic        in_range,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [9:0]  millisecond
);

    logic        stalled;
    logic        res_oor;
    logic        res_inr;
    logic [49:0] res_bits;
    logic        out_zero;
    logic        date_in_bounds;
    logic        time_in_bounds;

    assign stalled  = cal_valid && !cal_ready;
    assign res_oor  = cal_valid && !in_range;
    assign res_inr  = cal_valid && in_range;
    assign res_bits = {cal_valid, in_range, year, month, day_of_month,
                       hour, minute, second, millisecond};

    assign out_zero = (year == 12'd0) && (month == 4'd0) && (day_of_month == 5'd0)
                      && (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0)
                      && (millisecond == 10'd0);

    assign date_in_bounds = (year >= 12'd1970) && (year <= 12'd4001)
                            && (month >= 4'd1) && (month <= 4'd12)
                            && (day_of_month != 5'd0);

    assign time_in_bounds = (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
                            && (millisecond <= 10'd999);

    // a stalled result holds
    `EP2C_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, $stable(res_bits), "result moved")

    // input back-pressure only while the output is stalled
    `EP2C_ASSERT_SAME(a_full_only, clk, rst_n, !ms_ready, stalled, "input stalled with room")

    // out of range gives all-zero fields
    `EP2C_ASSERT_SAME(a_zero_fields, clk, rst_n, res_oor, out_zero, "fields not zero out of range")

    // in range gives a real date
    `EP2C_ASSERT_SAME(a_date_ok, clk, rst_n, res_inr, date_in_bounds, "date field out of bounds")

    // in range gives a real time of day
    `EP2C_ASSERT_SAME(a_time_ok, clk, rst_n, res_inr, time_in_bounds, "time field out of bounds")

endmodule

bind epoch_ms_to_calendar epoch_ms_to_calendar_chk u_chk (.*);
